### rtl/core/ps2kt_pkg.sv
// Package for the PS/2 scancode translator: payload types, command and event codes,
// configuration register indexes and fixed scancode constants. No dependencies.
package ps2kt_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] code_byte;
    logic [7:0] map_entry;
    logic       drive_level;
  } item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] key_out;
    logic       key_pressed;
    logic       led_write;
    logic [2:0] led_bits;
  } result_t;

  localparam int unsigned CfgIndexW = 3;

  typedef struct packed {
    logic [CfgIndexW-1:0] reg_index;
    logic [8:0]           wdata;
  } cfg_t;

  localparam logic [1:0] CMD_SCAN      = 2'd0;
  localparam logic [1:0] CMD_WR_NORMAL = 2'd1;
  localparam logic [1:0] CMD_WR_EXT    = 2'd2;
  localparam logic [1:0] CMD_DRIVE     = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_KEY     = 2'd1;
  localparam logic [1:0] EV_UNKNOWN = 2'd2;
  localparam logic [1:0] EV_RESET   = 2'd3;

  localparam logic [CfgIndexW-1:0] REG_CTRL_KEY       = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_LEFT_META_KEY  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_RIGHT_META_KEY = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_NORMAL_LIMIT   = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_EXTENDED_LIMIT = 3'd4;

  localparam logic [7:0] CODE_EXT   = 8'he0;
  localparam logic [7:0] CODE_EXT2  = 8'he1;
  localparam logic [7:0] CODE_BREAK = 8'hf0;
  localparam logic [7:0] KEY_NONE   = 8'hff;
  localparam logic [7:0] KEY_CAPS   = 8'h62;

  localparam logic [7:0] CTRL_KEY_RESET       = 8'd99;
  localparam logic [7:0] LEFT_META_KEY_RESET  = 8'd102;
  localparam logic [7:0] RIGHT_META_KEY_RESET = 8'd103;
  localparam logic [8:0] LIMIT_RESET          = 9'd256;

endpackage

### rtl/core/ps2kt_chan_if.sv
// Valid/ready channel interface used for the item, result and configuration ports.
// The payload type is taken from ps2kt_pkg by the instantiating level.
interface ps2kt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ps2_keyboard_scancode_translator_core.sv
// Top level of the PS/2 set-2 scancode translator with its two keycode maps.
// Depends on ps2kt_pkg and ps2kt_chan_if.
//
// The item channel carries scancode bytes, map writes and drive-level updates; the
// result channel returns exactly one result for every item, in order. The cfg channel
// writes the modifier keycodes and map limits and is always ready; it is to be written
// only while the block is idle, which the user must ensure: the block does not enforce it.
// An item accepted at a clock edge has its fields, and for an in-range code its map
// entries, read into the first stage at that edge; its result is loaded into the output
// register, and result valid set, when the first stage advances, which a stalling
// receiver can delay. One item per cycle is sustained while the receiver does not stall:
// the synchronous map read and the flag update form a two-stage pipeline.
// While the receiver stalls, the output register holds its result and the first stage
// holds the following item; the item channel drops ready only when both are full.
// Reset clears the prefix flags, held modifiers, LED state, drive level and pipeline
// valid bits and restores the configuration defaults. The maps are not cleared and
// must be loaded before use; no clearing pass runs after reset.
module ps2_keyboard_scancode_translator_core #(
  parameter int unsigned MAP_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  ps2kt_chan_if.sink   item,
  ps2kt_chan_if.source result,
  ps2kt_chan_if.sink   cfg
);

  localparam int unsigned AddrW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [8:0]  DepthW9 = 9'(MAP_DEPTH);

  logic [7:0] ctrl_key;
  logic [7:0] left_meta_key;
  logic [7:0] right_meta_key;
  logic [8:0] normal_limit;
  logic [8:0] extended_limit;

  logic       brk;
  logic       ext;
  logic       ext2;
  logic [2:0] mods;
  logic [2:0] led_reg;
  logic       last_lvl;

  logic       brk_next;
  logic       ext_next;
  logic       ext2_next;
  logic [2:0] mods_next;
  logic [2:0] led_reg_next;
  logic       last_lvl_next;

  logic [7:0] nrm_mem [MAP_DEPTH];
  logic [7:0] ext_mem [MAP_DEPTH];

  logic             s1_valid;
  logic [1:0]       s1_cmd;
  logic [7:0]       s1_code;
  logic             s1_lvl;
  logic             s1_in_range;
  logic [7:0]       s1_nrm_q;
  logic [7:0]       s1_ext_q;

  logic             out_valid;
  ps2kt_pkg::item_t   item_d;
  ps2kt_pkg::result_t out_q;
  ps2kt_pkg::result_t res_next;

  logic             item_fire;
  logic             s1_adv;
  logic             s1_fire;
  logic             in_range;
  logic [AddrW-1:0] addr;

  logic [7:0] kc;
  logic       press;
  logic [2:0] mods_upd;

  assign item_d    = item.data;
  assign in_range  = ({1'b0, item_d.code_byte} < DepthW9);
  assign addr      = item_d.code_byte[AddrW-1:0];
  assign s1_adv    = !out_valid || result.ready;
  assign s1_fire   = s1_valid && s1_adv;
  assign item.ready = !s1_valid || s1_adv;
  assign item_fire = item.valid && item.ready;

  assign result.valid = out_valid;
  assign result.data  = out_q;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_key       <= ps2kt_pkg::CTRL_KEY_RESET;
      left_meta_key  <= ps2kt_pkg::LEFT_META_KEY_RESET;
      right_meta_key <= ps2kt_pkg::RIGHT_META_KEY_RESET;
      normal_limit   <= ps2kt_pkg::LIMIT_RESET;
      extended_limit <= ps2kt_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        ps2kt_pkg::REG_CTRL_KEY:       ctrl_key       <= cfg.data.wdata[7:0];
        ps2kt_pkg::REG_LEFT_META_KEY:  left_meta_key  <= cfg.data.wdata[7:0];
        ps2kt_pkg::REG_RIGHT_META_KEY: right_meta_key <= cfg.data.wdata[7:0];
        ps2kt_pkg::REG_NORMAL_LIMIT:   normal_limit   <= cfg.data.wdata;
        ps2kt_pkg::REG_EXTENDED_LIMIT: extended_limit <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  // Both maps are read on every accepted item with an in-range code; the flags pick one in the next stage.
  always_ff @(posedge clk) begin
    if (item_fire && in_range) begin
      if (item_d.cmd == ps2kt_pkg::CMD_WR_NORMAL) begin
        nrm_mem[addr] <= item_d.map_entry;
      end
      if (item_d.cmd == ps2kt_pkg::CMD_WR_EXT) begin
        ext_mem[addr] <= item_d.map_entry;
      end
      s1_nrm_q <= nrm_mem[addr];
      s1_ext_q <= ext_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_cmd      <= item_d.cmd;
      s1_code     <= item_d.code_byte;
      s1_lvl      <= item_d.drive_level;
      s1_in_range <= in_range;
    end
  end

  always_comb begin
    brk_next      = brk;
    ext_next      = ext;
    ext2_next     = ext2;
    mods_next     = mods;
    led_reg_next  = led_reg;
    last_lvl_next = last_lvl;
    res_next      = '0;
    kc            = ps2kt_pkg::KEY_NONE;
    press         = !brk;
    mods_upd      = mods;
    unique case (s1_cmd)
      ps2kt_pkg::CMD_SCAN: begin
        if (s1_code == ps2kt_pkg::CODE_EXT) begin
          ext_next = 1'b1;
        end else if (s1_code == ps2kt_pkg::CODE_EXT2) begin
          ext2_next = 1'b1;
        end else if (s1_code == ps2kt_pkg::CODE_BREAK) begin
          brk_next = 1'b1;
        end else begin
          if (ext) begin
            if (s1_in_range && ({1'b0, s1_code} < extended_limit)) begin
              kc = s1_ext_q;
            end
          end else if (!ext2) begin
            if (s1_in_range && ({1'b0, s1_code} < normal_limit)) begin
              kc = s1_nrm_q;
            end
          end
          if (kc != ps2kt_pkg::KEY_NONE) begin
            if (kc == ctrl_key) begin
              mods_upd[0] = press;
            end else if (kc == left_meta_key) begin
              mods_upd[1] = press;
            end else if (kc == right_meta_key) begin
              mods_upd[2] = press;
            end
          end
          if (mods_upd == 3'b111) begin
            res_next.event_kind = ps2kt_pkg::EV_RESET;
            mods_next = '0;
          end else begin
            mods_next = mods_upd;
            if (kc != ps2kt_pkg::KEY_NONE) begin
              res_next.event_kind  = ps2kt_pkg::EV_KEY;
              res_next.key_out     = kc;
              res_next.key_pressed = press;
              if (kc == ps2kt_pkg::KEY_CAPS && press) begin
                led_reg_next[2]    = !led_reg[2];
                res_next.led_write = 1'b1;
              end
            end else begin
              res_next.event_kind = ps2kt_pkg::EV_UNKNOWN;
            end
          end
          brk_next  = 1'b0;
          ext_next  = 1'b0;
          ext2_next = 1'b0;
        end
      end
      ps2kt_pkg::CMD_DRIVE: begin
        if (s1_lvl != last_lvl) begin
          last_lvl_next      = s1_lvl;
          led_reg_next[0]    = s1_lvl;
          res_next.led_write = 1'b1;
        end
      end
      default: ;
    endcase
    res_next.led_bits = led_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      brk       <= 1'b0;
      ext       <= 1'b0;
      ext2      <= 1'b0;
      mods      <= '0;
      led_reg   <= '0;
      last_lvl  <= 1'b0;
    end else begin
      if (item_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
        brk       <= brk_next;
        ext       <= ext_next;
        ext2      <= ext2_next;
        mods      <= mods_next;
        led_reg   <= led_reg_next;
        last_lvl  <= last_lvl_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_q <= res_next;
    end
  end

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> s1_valid && out_valid && !result.ready)
    else $error("item channel stalled while the pipeline had room");

  a_led_change_signalled: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(led_reg) |-> $past(s1_fire) && $past(res_next.led_write))
    else $error("LED state changed without an LED rewrite");

  a_mods_never_all_held: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> mods != 3'b111)
    else $error("all three modifiers left held after a step");

  a_key_event_mapped: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.event_kind == ps2kt_pkg::EV_KEY |-> out_q.key_out != ps2kt_pkg::KEY_NONE)
    else $error("key event carries the unmapped keycode");

endmodule
